>>> hw/rtl/oaht_pkg.sv
`timescale 1ns / 1ps

package oaht_pkg;

    localparam int KEY_W      = 64;
    localparam int NUMBER_W   = 34;
    localparam int PROBES_W   = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int BYTE_W     = 8;
    localparam int MAX_KEY_BYTES = 8;

    localparam logic OP_SEARCH      = 1'b1;
    localparam logic MODE_QUADRATIC = 1'b1;
    localparam logic REG_PROBE_MODE = 1'b0;

    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FOUND     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_SUM,
        CTL_MOD,
        CTL_READ,
        CTL_CHECK
    } ctl_state_t;

    typedef struct packed {
        logic                used;
        logic [KEY_W-1:0]    key;
        logic [NUMBER_W-1:0] number;
        logic [PROBES_W-1:0] probes;
    } entry_t;

    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    sum;
        logic    mod_step;
        logic    advance;
        logic    ins_wr;
        logic    finish;
        status_t res_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic is_search;
        logic used;
        logic match;
        logic probe_last;
    } ctl_stat_t;

endpackage

>>> hw/rtl/oaht_ram.sv
`timescale 1ns / 1ps

module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/oaht_ctrl.sv
`timescale 1ns / 1ps

module oaht_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  oaht_pkg::ctl_stat_t  stat,
    output oaht_pkg::ctl_cmd_t   cmd,
    output logic                 busy
);

    oaht_pkg::ctl_state_t state_reg;
    oaht_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oaht_pkg::CTL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oaht_pkg::CTL_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = oaht_pkg::CTL_IDLE;
                end
            end
            oaht_pkg::CTL_IDLE:
            begin
                if (start)
                begin
                    state_next = oaht_pkg::CTL_SUM;
                end
            end
            oaht_pkg::CTL_SUM:
            begin
                state_next = oaht_pkg::CTL_MOD;
            end
            oaht_pkg::CTL_MOD:
            begin
                if (stat.mod_last)
                begin
                    state_next = oaht_pkg::CTL_READ;
                end
            end
            oaht_pkg::CTL_READ:
            begin
                state_next = oaht_pkg::CTL_CHECK;
            end
            oaht_pkg::CTL_CHECK:
            begin
                if (!stat.used || stat.probe_last || (stat.is_search && stat.match))
                begin
                    state_next = oaht_pkg::CTL_IDLE;
                end
                else
                begin
                    state_next = oaht_pkg::CTL_READ;
                end
            end
            default:
            begin
                state_next = oaht_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = oaht_pkg::STATUS_NOT_FOUND;
        busy           = 1'b1;
        case (state_reg)
            oaht_pkg::CTL_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            oaht_pkg::CTL_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            oaht_pkg::CTL_SUM:
            begin
                cmd.sum = 1'b1;
            end
            oaht_pkg::CTL_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            oaht_pkg::CTL_READ:
            begin
            end
            oaht_pkg::CTL_CHECK:
            begin
                if (stat.is_search)
                begin
                    if (!stat.used)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = oaht_pkg::STATUS_NOT_FOUND;
                    end
                    else if (stat.match)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = oaht_pkg::STATUS_FOUND;
                    end
                    else if (stat.probe_last)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = oaht_pkg::STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    if (!stat.used)
                    begin
                        cmd.ins_wr     = 1'b1;
                        cmd.finish     = 1'b1;
                        cmd.res_status = oaht_pkg::STATUS_INSERTED;
                    end
                    else if (stat.probe_last)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = oaht_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == oaht_pkg::CTL_IDLE && start) |=> state_reg == oaht_pkg::CTL_SUM)
        else $error("accepted request did not enter the sum step");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == oaht_pkg::CTL_IDLE)
        else $error("controller not idle after finishing a request");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == oaht_pkg::CTL_CHECK) |-> $past(state_reg) == oaht_pkg::CTL_READ)
        else $error("slot checked without a preceding read");
`endif

endmodule

>>> hw/rtl/oaht_datapath.sv
`timescale 1ns / 1ps

module oaht_datapath #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_BYTES  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 probe_mode,
    input  logic                                 opcode,
    input  logic [oaht_pkg::KEY_W-1:0]           key_text,
    input  logic [oaht_pkg::NUMBER_W-1:0]        phone_number,
    input  oaht_pkg::ctl_cmd_t                   cmd,
    output oaht_pkg::ctl_stat_t                  stat,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]      slot_index,
    output logic [oaht_pkg::NUMBER_W-1:0]        found_number,
    output logic [oaht_pkg::PROBES_W-1:0]        probe_count
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int K_W    = $clog2(TABLE_SIZE + 1);
    localparam int SUM_W  = $clog2(KEY_BYTES * 255 + 1);
    localparam int J_W    = 1;
    localparam int WIDE_W = SUM_W + IDX_W + 1;
    localparam int ENTRY_W = $bits(oaht_pkg::entry_t);

    localparam logic [WIDE_W-1:0] TS_WIDE   = WIDE_W'(TABLE_SIZE);
    localparam logic [IDX_W:0]    TS_IDX    = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [K_W-1:0]    LAST_K    = K_W'(TABLE_SIZE - 1);
    localparam logic [J_W-1:0]    FIRST_J   = J_W'(1);
    localparam logic [SUM_W-1:0]  RECIP     = SUM_W'((1 << SUM_W) / TABLE_SIZE);
    localparam logic [oaht_pkg::PROBES_W-1:0] FULL_PROBES =
        (TABLE_SIZE > 31) ? 5'd31 : 5'(TABLE_SIZE);

    logic                          op_reg, op_next;
    logic [oaht_pkg::KEY_W-1:0]    raw_key_reg, raw_key_next;
    logic [oaht_pkg::NUMBER_W-1:0] number_reg, number_next;
    logic [oaht_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [SUM_W-1:0]              rem_reg, rem_next;
    logic [SUM_W-1:0]              quot_reg, quot_next;
    logic [J_W-1:0]                j_reg, j_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    logic [IDX_W-1:0]              step_reg, step_next;
    logic [K_W-1:0]                k_reg, k_next;
    logic [IDX_W-1:0]              clr_addr_reg, clr_addr_next;
    logic                          done_reg, done_next;
    oaht_pkg::status_t             status_reg, status_next;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [oaht_pkg::NUMBER_W-1:0] found_reg, found_next;
    logic [oaht_pkg::PROBES_W-1:0] probes_reg, probes_next;

    logic [oaht_pkg::KEY_W-1:0]    clean_key;
    logic [SUM_W-1:0]              clean_sum;
    logic [2*SUM_W-1:0]            quot_prod;
    logic [WIDE_W-1:0]             quot_back;
    logic [WIDE_W-1:0]             rem_raw;
    logic [WIDE_W-1:0]             home;
    logic [IDX_W-1:0]              step_sel;
    logic [IDX_W:0]                pos_sum;
    logic [IDX_W-1:0]              pos_adv;
    logic [IDX_W:0]                step_sum;
    logic [IDX_W-1:0]              step_adv;
    logic [oaht_pkg::PROBES_W-1:0] k_probes;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    oaht_pkg::entry_t              wr_entry;
    logic [ENTRY_W-1:0]            rd_word;
    oaht_pkg::entry_t              rd_entry;

    always_comb
    begin : clean_keys
        logic                        alive;
        logic [oaht_pkg::BYTE_W-1:0] kb;
        alive     = 1'b1;
        clean_key = '0;
        clean_sum = '0;
        for (int b = 0; b < oaht_pkg::MAX_KEY_BYTES; b++)
        begin
            kb = raw_key_reg[oaht_pkg::BYTE_W*b +: oaht_pkg::BYTE_W];
            if (b >= KEY_BYTES || kb == '0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                clean_key[oaht_pkg::BYTE_W*b +: oaht_pkg::BYTE_W] = kb;
                clean_sum = clean_sum + SUM_W'(kb);
            end
        end
    end

    assign quot_prod = {{SUM_W{1'b0}}, rem_reg} * {{SUM_W{1'b0}}, RECIP};
    assign quot_back = WIDE_W'(quot_reg) * TS_WIDE;
    assign rem_raw   = WIDE_W'(rem_reg) - quot_back;
    assign home      = (rem_raw >= TS_WIDE) ? (rem_raw - TS_WIDE) : rem_raw;

    assign step_sel = (probe_mode == oaht_pkg::MODE_QUADRATIC) ? step_reg : IDX_W'(1);
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_sel};
    assign pos_adv  = (pos_sum >= TS_IDX) ? IDX_W'(pos_sum - TS_IDX) : pos_sum[IDX_W-1:0];
    assign step_sum = {1'b0, step_reg} + (IDX_W + 1)'(2);
    assign step_adv = (step_sum >= TS_IDX) ? IDX_W'(step_sum - TS_IDX) : step_sum[IDX_W-1:0];

    assign k_probes = (32'(k_reg) > 32'd31) ? 5'd31 : 5'(k_reg);

    assign wr_en   = cmd.clear_wr || cmd.ins_wr;
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : pos_reg;

    always_comb
    begin
        wr_entry = '0;
        if (!cmd.clear_wr)
        begin
            wr_entry.used   = 1'b1;
            wr_entry.key    = key_reg;
            wr_entry.number = number_reg;
            wr_entry.probes = k_probes;
        end
    end

    oaht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (pos_reg),
        .rd_data (rd_word)
    );

    assign rd_entry = oaht_pkg::entry_t'(rd_word);

    assign stat.clear_last = (clr_addr_reg == LAST_IDX);
    assign stat.mod_last   = (j_reg == '0);
    assign stat.is_search  = (op_reg == oaht_pkg::OP_SEARCH);
    assign stat.used       = rd_entry.used;
    assign stat.match      = (rd_entry.key == key_reg);
    assign stat.probe_last = (k_reg == LAST_K);

    always_comb
    begin
        op_next       = op_reg;
        raw_key_next  = raw_key_reg;
        number_next   = number_reg;
        key_next      = key_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        j_next        = j_reg;
        pos_next      = pos_reg;
        step_next     = step_reg;
        k_next        = k_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = cmd.finish;
        status_next   = status_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        probes_next   = probes_reg;

        if (cmd.clear_wr)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
        end
        if (cmd.load)
        begin
            op_next      = opcode;
            raw_key_next = key_text;
            number_next  = phone_number;
        end
        if (cmd.sum)
        begin
            key_next = clean_key;
            rem_next = clean_sum;
            j_next   = FIRST_J;
        end
        if (cmd.mod_step)
        begin
            j_next = j_reg - J_W'(1);
            if (stat.mod_last)
            begin
                pos_next  = IDX_W'(home);
                step_next = IDX_W'(1);
                k_next    = '0;
            end
            else
            begin
                quot_next = quot_prod[2*SUM_W-1:SUM_W];
            end
        end
        if (cmd.advance)
        begin
            pos_next  = pos_adv;
            step_next = step_adv;
            k_next    = k_reg + K_W'(1);
        end
        if (cmd.finish)
        begin
            status_next = cmd.res_status;
            slot_next   = '0;
            found_next  = '0;
            probes_next = '0;
            case (cmd.res_status)
                oaht_pkg::STATUS_INSERTED:
                begin
                    slot_next   = oaht_pkg::SLOT_OUT_W'(pos_reg);
                    probes_next = k_probes;
                end
                oaht_pkg::STATUS_FOUND:
                begin
                    slot_next   = oaht_pkg::SLOT_OUT_W'(pos_reg);
                    found_next  = rd_entry.number;
                    probes_next = rd_entry.probes;
                end
                oaht_pkg::STATUS_FULL:
                begin
                    probes_next = FULL_PROBES;
                end
                default:
                begin
                    probes_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        raw_key_reg <= raw_key_next;
        number_reg  <= number_next;
        key_reg     <= key_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        j_reg       <= j_next;
        pos_reg     <= pos_next;
        step_reg    <= step_next;
        k_reg       <= k_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        probes_reg  <= probes_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_index   = slot_reg;
    assign found_number = found_reg;
    assign probe_count  = probes_reg;

endmodule

>>> hw/rtl/open_addressing_hash_table.sv
`timescale 1ns / 1ps

// Open-addressing hash table of key / telephone-number pairs.
// Request channel: drive opcode, key_text and phone_number with start high;
// the request is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with status, slot_index,
// found_number and probe_count valid; the receiver cannot stall it.
// A request first cleans and sums the key, then reduces the sum modulo
// TABLE_SIZE by reciprocal multiplication for the home slot, then reads and
// checks one slot per probe through the single registered-read table
// memory.
// A request makes 1 to TABLE_SIZE probes; done rises in the same cycle as
// busy falls, so a new request can be taken while done is shown, but not
// before the previous request has finished.
// After reset the table is swept clear, one slot a cycle, over all TABLE_SIZE
// slots with busy high; the APB register is writable throughout.
// Register 0 (byte address 0), bit 0: probe_mode, 0 linear, 1 quadratic.
// Write it only while busy is low.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = 16,
    parameter int KEY_BYTES  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [oaht_pkg::KEY_W-1:0]         key_text,
    input  logic [oaht_pkg::NUMBER_W-1:0]      phone_number,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [oaht_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic [oaht_pkg::NUMBER_W-1:0]      found_number,
    output logic [oaht_pkg::PROBES_W-1:0]      probe_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    oaht_pkg::ctl_cmd_t  cmd;
    oaht_pkg::ctl_stat_t stat;

    logic probe_mode_reg;
    logic probe_mode_next;

    assign pready = 1'b1;

    always_comb
    begin
        probe_mode_next = probe_mode_reg;
        if (psel && penable && pwrite && pready && paddr[2] == oaht_pkg::REG_PROBE_MODE)
        begin
            probe_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_mode_reg <= 1'b0;
        end
        else
        begin
            probe_mode_reg <= probe_mode_next;
        end
    end

    assign prdata = (paddr[2] == oaht_pkg::REG_PROBE_MODE) ? {31'd0, probe_mode_reg} : 32'd0;

    oaht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    oaht_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .probe_mode   (probe_mode_reg),
        .opcode       (opcode),
        .key_text     (key_text),
        .phone_number (phone_number),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .slot_index   (slot_index),
        .found_number (found_number),
        .probe_count  (probe_count)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still running");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_SIZE = 16;
    localparam int KEY_BYTES  = 8;

    localparam logic       OP_INSERT       = ~oaht_pkg::OP_SEARCH;
    localparam logic       MODE_LINEAR     = ~oaht_pkg::MODE_QUADRATIC;
    localparam logic [2:0] ADDR_PROBE_MODE = {oaht_pkg::REG_PROBE_MODE, 2'b00};

    localparam logic [oaht_pkg::KEY_W-1:0] KEY_EMPTY   = 64'h0;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_AB      = 64'h4241;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_BA      = 64'h4142;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_CA      = 64'h4143;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_AT_C    = 64'h4340;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_C_AT    = 64'h4043;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_ALL_FF  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_LEAD_0  = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [oaht_pkg::KEY_W-1:0] KEY_AB_JUNK = 64'hFF00_0000_0000_4241;

    typedef struct packed {
        oaht_pkg::status_t               st;
        logic [oaht_pkg::SLOT_OUT_W-1:0] slot;
        logic [oaht_pkg::NUMBER_W-1:0]   number;
        logic [oaht_pkg::PROBES_W-1:0]   probes;
    } lookup_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            opcode = 1'b0;
    logic [oaht_pkg::KEY_W-1:0]      key_text = '0;
    logic [oaht_pkg::NUMBER_W-1:0]   phone_number = '0;
    logic                            done;
    logic [1:0]                      status;
    logic [oaht_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [oaht_pkg::NUMBER_W-1:0]   found_number;
    logic [oaht_pkg::PROBES_W-1:0]   probe_count;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    logic                          table_used [TABLE_SIZE];
    logic [oaht_pkg::KEY_W-1:0]    table_key [TABLE_SIZE];
    logic [oaht_pkg::NUMBER_W-1:0] table_number [TABLE_SIZE];
    logic [oaht_pkg::PROBES_W-1:0] table_probes [TABLE_SIZE];
    logic                          mode_now = 1'b0;

    lookup_t                    lookups_due [$];
    logic [oaht_pkg::KEY_W-1:0] key_pool [$];
    int                         mismatches = 0;

    open_addressing_hash_table #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_BYTES(KEY_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .key_text(key_text),
        .phone_number(phone_number),
        .done(done),
        .status(status),
        .slot_index(slot_index),
        .found_number(found_number),
        .probe_count(probe_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            table_used[i] = 1'b0;
        end
    end

    function automatic int unsigned probe_position(input int unsigned total,
                                                   input int unsigned k);
        if (mode_now == oaht_pkg::MODE_QUADRATIC)
            return (total + k * k) % TABLE_SIZE;
        return ((total % TABLE_SIZE) + k) % TABLE_SIZE;
    endfunction

    function automatic lookup_t predict_lookup(input logic op,
                                               input logic [oaht_pkg::KEY_W-1:0] raw,
                                               input logic [oaht_pkg::NUMBER_W-1:0] num);
        lookup_t                    res;
        logic [oaht_pkg::KEY_W-1:0] key;
        int unsigned                total;
        int unsigned                s;
        bit                         ended;
        bit                         settled;
        res.st = oaht_pkg::STATUS_NOT_FOUND;
        res.slot = '0;
        res.number = '0;
        res.probes = '0;
        key = '0;
        total = 0;
        ended = 1'b0;
        settled = 1'b0;
        // keep bytes up to the first zero byte
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
            begin
                key[8*b +: 8] = raw[8*b +: 8];
                total += raw[8*b +: 8];
            end
        end
        if (op == OP_INSERT)
        begin
            res.st = oaht_pkg::STATUS_FULL;
            res.probes = oaht_pkg::PROBES_W'(TABLE_SIZE > 31 ? 31 : TABLE_SIZE);
            for (int unsigned k = 0; k < TABLE_SIZE && !settled; k++)
            begin
                s = probe_position(total, k);
                if (!table_used[s])
                begin
                    table_used[s] = 1'b1;
                    table_key[s] = key;
                    table_number[s] = num;
                    table_probes[s] = oaht_pkg::PROBES_W'(k > 31 ? 31 : k);
                    res.st = oaht_pkg::STATUS_INSERTED;
                    res.slot = oaht_pkg::SLOT_OUT_W'(s);
                    res.probes = oaht_pkg::PROBES_W'(k > 31 ? 31 : k);
                    settled = 1'b1;
                end
            end
        end
        else
        begin
            for (int unsigned k = 0; k < TABLE_SIZE && !settled; k++)
            begin
                s = probe_position(total, k);
                if (!table_used[s])
                    settled = 1'b1;
                else if (table_key[s] == key)
                begin
                    res.st = oaht_pkg::STATUS_FOUND;
                    res.slot = oaht_pkg::SLOT_OUT_W'(s);
                    res.number = table_number[s];
                    res.probes = table_probes[s];
                    settled = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [oaht_pkg::KEY_W-1:0] fresh_key();
        logic [oaht_pkg::KEY_W-1:0] raw;
        int                         len;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
        begin
            len = $urandom_range(0, KEY_BYTES);
            for (int b = 0; b < KEY_BYTES; b++)
            begin
                if (b < len)
                    raw[8*b +: 8] = 8'($urandom_range(1, 255));
                else if (b == len)
                    raw[8*b +: 8] = 8'h00;
            end
        end
        return raw;
    endfunction

    always @(negedge clk)
    begin
        lookup_t want;
        if (rst_n && done === 1'b1)
        begin
            if (lookups_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, status, slot_index);
            end
            else
            begin
                want = lookups_due.pop_front();
                if (status !== want.st)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
                if (slot_index !== want.slot)
                begin
                    mismatches++;
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, want.slot, slot_index);
                end
                if (found_number !== want.number)
                begin
                    mismatches++;
                    $display("%0t: found_number expected %0d actual %0d",
                             $time, want.number, found_number);
                end
                if (probe_count !== want.probes)
                begin
                    mismatches++;
                    $display("%0t: probe_count expected %0d actual %0d",
                             $time, want.probes, probe_count);
                end
            end
        end
    end

    task automatic send_request(input logic op, input logic [oaht_pkg::KEY_W-1:0] raw,
                                input logic [oaht_pkg::NUMBER_W-1:0] num);
        logic free;
        start <= 1'b1;
        opcode <= op;
        key_text <= raw;
        phone_number <= num;
        free = 1'b0;
        while (!free)
        begin
            @(negedge clk);
            free = (busy === 1'b0);
            @(posedge clk);
        end
        lookups_due.push_back(predict_lookup(op, raw, num));
        if (op == OP_INSERT)
        begin
            key_pool.push_back(raw);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic idle_burst(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (lookups_due.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_probe_mode(input logic mode);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PROBE_MODE;
        pwdata <= {31'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_now = mode;
    endtask

    task automatic test_empty_table();
        wait_drained();
        write_probe_mode(MODE_LINEAR);
        send_request(oaht_pkg::OP_SEARCH, KEY_AB, '0);
        send_request(oaht_pkg::OP_SEARCH, KEY_EMPTY, '1);
    endtask

    task automatic test_linear_probing();
        send_request(OP_INSERT, KEY_AB, 34'd5551234567);
        send_request(OP_INSERT, KEY_BA, 34'd9999999999);
        send_request(OP_INSERT, KEY_ALL_FF, '1);
        send_request(oaht_pkg::OP_SEARCH, KEY_BA, '0);
    endtask

    task automatic test_key_cleaning();
        send_request(OP_INSERT, KEY_EMPTY, '0);
        send_request(OP_INSERT, KEY_LEAD_0, 34'd1);
        send_request(oaht_pkg::OP_SEARCH, KEY_EMPTY, '0);
        send_request(oaht_pkg::OP_SEARCH, KEY_AB_JUNK, '0);
        send_request(oaht_pkg::OP_SEARCH, KEY_CA, '0);
    endtask

    task automatic test_quadratic_probing();
        wait_drained();
        write_probe_mode(oaht_pkg::MODE_QUADRATIC);
        send_request(OP_INSERT, KEY_AB, 34'd1234);
        send_request(OP_INSERT, KEY_AT_C, 34'd4321);
        send_request(OP_INSERT, KEY_CA, 34'd777);
        // every quadratic position of this home is taken, though other slots are still free
        send_request(OP_INSERT, KEY_C_AT, 34'd888);
        send_request(oaht_pkg::OP_SEARCH, KEY_C_AT, '0);
        send_request(oaht_pkg::OP_SEARCH, KEY_AT_C, '0);
    endtask

    task automatic test_mode_switch();
        wait_drained();
        write_probe_mode(MODE_LINEAR);
        send_request(oaht_pkg::OP_SEARCH, KEY_AT_C, '0);
    endtask

    task automatic run_random(input int count, input int search_pct, input int idle_pct);
        logic                       op;
        logic [oaht_pkg::KEY_W-1:0] raw;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(99) < search_pct) ? oaht_pkg::OP_SEARCH : OP_INSERT;
            if (key_pool.size() != 0 && $urandom_range(99) < 60)
                raw = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                raw = fresh_key();
            send_request(op, raw, {2'($urandom), 32'($urandom)});
            idle_burst(((i / 50) % 3 == 2) ? 0 : idle_pct);
        end
    endtask

    task automatic test_random_quadratic();
        wait_drained();
        write_probe_mode(oaht_pkg::MODE_QUADRATIC);
        run_random(240, 60, 30);
    endtask

    task automatic test_random_linear();
        wait_drained();
        write_probe_mode(MODE_LINEAR);
        run_random(240, 50, 30);
    endtask

    task automatic test_full_table();
        wait_drained();
        write_probe_mode(oaht_pkg::MODE_QUADRATIC);
        run_random(200, 70, 25);
        wait_drained();
        write_probe_mode(MODE_LINEAR);
        run_random(120, 70, 25);
        run_random(120, 60, 0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_linear_probing();
        test_key_cleaning();
        test_quadratic_probing();
        test_mode_switch();
        test_random_quadratic();
        test_random_linear();
        test_full_table();
        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && lookups_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_datapath.sv
hw/rtl/open_addressing_hash_table.sv
tb/sv/tb_top.sv
